// File: rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the PID controller step
// Register indexes, command codes, control law codes, fixed register widths and the
// status word that the serial arithmetic units report to the sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

	// fixed register widths
	localparam int GAIN_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LAW     = 3'd6;

	// command codes
	localparam logic CMD_COMPENSATE = 1'b0;
	localparam logic CMD_CHECK      = 1'b1;

	// control law codes
	localparam logic LAW_STANDARD = 1'b0;
	localparam logic LAW_SCALED   = 1'b1;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// File: rtl/core/pcs_mul.sv
// ----------------------------------------------------------------------------
// pcs_mul: bit-serial fixed point multiplier
// Shift-add over the gain magnitude, one bit per cycle, then drop the
// fraction bits toward zero and saturate to the data width.
// ----------------------------------------------------------------------------
module pcs_mul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [pcs_pkg::GAIN_W-1:0] gain,
	input  logic signed [DATA_WIDTH-1:0]  operand,
	output pcs_pkg::unit_stat_t           stat,
	output logic signed [DATA_WIDTH-1:0]  product
);

	localparam int GW = pcs_pkg::GAIN_W;
	localparam int PW = DATA_WIDTH + GW;
	localparam int SW = PW - FRAC_BITS;
	localparam int CW = $clog2(GW + 1);

	logic [DATA_WIDTH-1:0] hi_q;
	logic [GW-1:0]         lo_q;
	logic [DATA_WIDTH-1:0] mcand_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic signed [DATA_WIDTH-1:0] product_q;

	logic [DATA_WIDTH:0]   step_sum;
	logic [PW-1:0]         full;
	logic [SW-1:0]         shifted;
	logic                  ovf;
	logic [DATA_WIDTH-1:0] mag;
	logic signed [DATA_WIDTH-1:0] res;

	// one partial product per cycle
	assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// truncate fraction and saturate
	always_comb begin
		full    = {hi_q, lo_q};
		shifted = full[PW-1:FRAC_BITS];
		ovf     = |shifted[SW-1:DATA_WIDTH-1];
		mag     = {1'b0, shifted[DATA_WIDTH-2:0]};
		if (ovf) begin
			res = neg_q ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			res = neg_q ? -$signed(mag) : $signed(mag);
		end
	end

	// load, shift and finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(GW);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= gain[GW-1] ? GW'(-gain) : GW'(gain);
			mcand_q <= operand[DATA_WIDTH-1] ? DATA_WIDTH'(-operand) : DATA_WIDTH'(operand);
			neg_q   <= gain[GW-1] ^ operand[DATA_WIDTH-1];
		end else if (busy_q && cnt_q != '0) begin
			hi_q <= step_sum[DATA_WIDTH:1];
			lo_q <= {step_sum[0], lo_q[GW-1:1]};
		end else if (busy_q) begin
			product_q <= res;
		end
	end

	assign stat    = '{busy: busy_q, done: done_q};
	assign product = product_q;

endmodule

// File: rtl/core/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div: bit-serial fixed point divider
// Restoring division of the scaled dividend magnitude, one quotient bit
// per cycle, truncated toward zero and saturated to the data width.
// ----------------------------------------------------------------------------
module pcs_div #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output pcs_pkg::unit_stat_t          stat,
	output logic signed [DATA_WIDTH-1:0] quotient
);

	localparam int NW = DATA_WIDTH + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [DATA_WIDTH-1:0] rem_q;
	logic [NW-1:0]         qr_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic signed [DATA_WIDTH-1:0] quotient_q;

	logic [DATA_WIDTH:0]   trial;
	logic                  ge;
	logic [DATA_WIDTH:0]   diff;
	logic                  ovf;
	logic [DATA_WIDTH-1:0] mag;
	logic signed [DATA_WIDTH-1:0] res;

	// trial subtract of one bit
	assign trial = {rem_q, qr_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	// saturate quotient
	always_comb begin
		ovf = |qr_q[NW-1:DATA_WIDTH-1];
		mag = {1'b0, qr_q[DATA_WIDTH-2:0]};
		if (ovf) begin
			res = neg_q ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end else begin
			res = neg_q ? -$signed(mag) : $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qr_q  <= {(dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : DATA_WIDTH'(dividend)),
				{FRAC_BITS{1'b0}}};
			den_q <= divisor;
			neg_q <= dividend[DATA_WIDTH-1];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
			qr_q  <= {qr_q[NW-2:0], ge};
		end else if (busy_q) begin
			quotient_q <= res;
		end
	end

	assign stat     = '{busy: busy_q, done: done_q};
	assign quotient = quotient_q;

endmodule

// File: rtl/core/pid_controller_step.sv
// ----------------------------------------------------------------------------
// pid_controller_step: PID controller step with integral clamp
// Sequencer, state and limits around a serial multiplier and divider.
// ----------------------------------------------------------------------------
// Usage: a word on the slave stream carries an error sample in tdata and a
// command in tuser (0 compensate, 1 check). A compensate word answers one
// drive value on the master stream; a check word answers nothing and only
// updates the first-step and used flags. Gains and limits are written
// through the cfg_we / cfg_index / cfg_data port; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Standard law: P, D and I multiplies in turn; scaled law: P and D
// multiplies, then a divide by the error; first step: P multiply only;
// small sample (scaled law): no arithmetic. One word is worked on at a
// time, so the rate is set by the shared multiplier and the divider.
// The output register holds a finished result while the next word is taken
// in; a stalled receiver holds the sequencer only when that register is
// still full as the next result is ready.
// Reset clears the controller state: previous error and integral 0, first
// step set, gains 0, minimum output 0, other limits all ones, standard law.
// ----------------------------------------------------------------------------
module pid_controller_step #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [TDATA_W-1:0]               s_tdata,   // error_value
	input  logic                             s_tuser,   // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [TDATA_W-1:0]               m_tdata,   // control_out
	input  logic                             cfg_we,
	input  logic [pcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pcs_pkg::CFG_W-1:0]        cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int GW = pcs_pkg::GAIN_W;
	localparam int MW = pcs_pkg::LIMIT_W;
	localparam int LW = (DW > MW ? DW : MW) + 2;
	localparam int TW = (DW > 32 ? DW : 32) + 1;
	localparam int THR_RAW = ((1 << FRAC_BITS) + 500) / 1000;
	localparam int THR = THR_RAW < 1 ? 1 : THR_RAW;
	localparam logic signed [TW-1:0] THR_V = TW'(THR);
	localparam logic signed [LW-1:0] LIM_POS = {{(LW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [LW-1:0] LIM_NEG = -LIM_POS - 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_DIV,
		ST_SUM,
		ST_LIMIT
	} state_t;

	state_t state_q;

	// configuration
	logic signed [GW-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [MW-1:0]        min_out_q, max_out_q, max_int_q;
	logic                 law_q;

	// controller state
	logic signed [DW-1:0] prev_q, integral_q;
	logic                 first_q, used_q;

	// work registers
	logic signed [DW-1:0] e_q, diff_q, p_q, d_q, t_q, sum_q, out_q;
	logic                 small_q, out_valid_q;
	logic                 mul_start_q, div_start_q;
	logic signed [GW-1:0] mul_gain_q;
	logic signed [DW-1:0] mul_opd_q, div_num_q;

	pcs_pkg::unit_stat_t  mul_stat, div_stat;
	logic signed [DW-1:0] mul_res, div_res;

	logic                 in_acc;
	logic signed [DW-1:0] e_in;
	logic signed [DW-1:0] diff_in, integral_in, sum_sat, limited;
	logic                 small_in;

	function automatic logic signed [DW-1:0] sat_lw(input logic signed [LW-1:0] v);
		if (v > LIM_POS) begin
			return LIM_POS[DW-1:0];
		end else if (v < LIM_NEG) begin
			return LIM_NEG[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic logic signed [LW-1:0] ext(input logic signed [DW-1:0] v);
		return {{(LW-DW){v[DW-1]}}, v};
	endfunction

	pcs_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.gain    (mul_gain_q),
		.operand (mul_opd_q),
		.stat    (mul_stat),
		.product (mul_res)
	);

	pcs_div #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_num_q),
		.divisor  (e_q),
		.stat     (div_stat),
		.quotient (div_res)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign e_in     = s_tdata[DW-1:0];
	assign small_in = $signed({{(TW-DW){e_in[DW-1]}}, e_in}) < THR_V;

	// saturated difference and clamped integral of the incoming word
	always_comb begin
		logic signed [LW-1:0] lim, acc;
		diff_in = sat_lw(ext(e_in) - ext(prev_q));
		lim = $signed({{(LW-MW){1'b0}}, max_int_q});
		if (lim > LIM_POS) begin
			lim = LIM_POS;
		end
		acc = ext(integral_q) + ext(e_in);
		if (acc > lim) begin
			acc = lim;
		end
		if (acc < -lim) begin
			acc = -lim;
		end
		integral_in = acc[DW-1:0];
	end

	// exact sum of the three terms, saturated
	assign sum_sat = sat_lw(ext(p_q) + ext(d_q) + ext(t_q));

	// output limit and minimum push of the scaled law
	always_comb begin
		logic signed [LW-1:0] o, mx, mn;
		o  = ext(sum_q);
		mx = $signed({{(LW-MW){1'b0}}, max_out_q});
		mn = $signed({{(LW-MW){1'b0}}, min_out_q});
		if (o > mx) begin
			o = mx;
		end else if (o < -mx) begin
			o = -mx;
		end
		if (o < mn && o > 0) begin
			o = mn;
		end else if (o > -mn && o < 0) begin
			o = -mn;
		end
		limited = sat_lw(o);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			min_out_q <= '0;
			max_out_q <= '1;
			max_int_q <= '1;
			law_q     <= pcs_pkg::LAW_STANDARD;
		end else if (cfg_we) begin
			case (cfg_index)
				pcs_pkg::CFG_GAIN_P:  gain_p_q  <= cfg_data;
				pcs_pkg::CFG_GAIN_I:  gain_i_q  <= cfg_data;
				pcs_pkg::CFG_GAIN_D:  gain_d_q  <= cfg_data;
				pcs_pkg::CFG_MIN_OUT: min_out_q <= cfg_data[MW-1:0];
				pcs_pkg::CFG_MAX_OUT: max_out_q <= cfg_data[MW-1:0];
				pcs_pkg::CFG_MAX_INT: max_int_q <= cfg_data[MW-1:0];
				pcs_pkg::CFG_LAW:     law_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			integral_q  <= '0;
			first_q     <= 1'b1;
			used_q      <= 1'b0;
			small_q     <= 1'b0;
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == pcs_pkg::CMD_CHECK) begin
						if (!used_q) begin
							first_q <= 1'b1;
						end
						used_q <= 1'b0;
					end else if (in_acc) begin
						used_q <= 1'b1;
						if (law_q == pcs_pkg::LAW_SCALED && small_in) begin
							small_q <= 1'b1;
							state_q <= ST_LIMIT;
						end else begin
							small_q <= 1'b0;
							if (first_q) begin
								integral_q <= '0;
							end else if (law_q == pcs_pkg::LAW_STANDARD) begin
								integral_q <= integral_in;
							end
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL_P;
						end
					end
				end
				ST_MUL_P: begin
					if (mul_stat.done) begin
						if (first_q) begin
							state_q <= ST_SUM;
						end else begin
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL_D;
						end
					end
				end
				ST_MUL_D: begin
					if (mul_stat.done) begin
						if (law_q == pcs_pkg::LAW_STANDARD) begin
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL_I;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_MUL_I: begin
					if (mul_stat.done) begin
						state_q <= ST_SUM;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						if (!small_q) begin
							prev_q  <= e_q;
							first_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				e_q        <= e_in;
				diff_q     <= diff_in;
				mul_gain_q <= gain_p_q;
				mul_opd_q  <= e_in;
				sum_q      <= '0;
			end
			ST_MUL_P: begin
				p_q        <= mul_res;
				d_q        <= '0;
				t_q        <= '0;
				mul_gain_q <= gain_d_q;
				mul_opd_q  <= diff_q;
			end
			ST_MUL_D: begin
				// the scaled law only uses the derivative through the quotient
				d_q        <= (law_q == pcs_pkg::LAW_STANDARD) ? mul_res : '0;
				div_num_q  <= mul_res;
				mul_gain_q <= gain_i_q;
				mul_opd_q  <= integral_q;
			end
			ST_MUL_I: t_q <= mul_res;
			ST_DIV:   t_q <= div_res;
			ST_SUM:   sum_q <= sum_sat;
			ST_LIMIT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= (law_q == pcs_pkg::LAW_SCALED) ? limited : sum_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'($unsigned(out_q));

	// the two serial units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy))
		else $error("multiplier and divider busy together");

	// a result is only ever loaded from the limit stage
	a_out_from_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_LIMIT)
		else $error("output loaded outside the limit stage");

	// a check word always leaves the used flag clear
	a_check_clears_used: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == pcs_pkg::CMD_CHECK |=> !used_q)
		else $error("used flag not cleared by check");

	// a compensate word always sets the used flag
	a_comp_sets_used: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == pcs_pkg::CMD_COMPENSATE |=> used_q)
		else $error("used flag not set by compensate");

endmodule

// File: tb/pid_controller_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_step_test: self-checking bench for the PID controller step
// Streams compensate and check words through the block under several gain
// and limit settings in both control laws. A scoreboard class keeps its own
// copy of the controller state and predicts every drive value; each word on
// the master stream is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_controller_step_test;

	localparam int  DW       = 32;
	localparam int  FB       = 16;
	localparam longint POS_LIM = 64'sd2147483647;
	localparam longint NEG_LIM = -64'sd2147483648;
	// 0.001 rounded to the nearest code at 16 fraction bits
	localparam longint SMALL_THR = 66;
	localparam int  SETTLE   = 200;

	// ------------------------------------------------------------------------
	// scoreboard: controller state, register copy and pending drive values
	// ------------------------------------------------------------------------
	class pid_law_scoreboard;
		longint    kp, ki, kd, out_min, out_max, int_max;
		logic      law;
		longint    prev_err, integ;
		bit        first, used;
		logic [DW-1:0] drive_q[$];
		int        mismatches;

		function new();
			kp = 0; ki = 0; kd = 0; out_min = 0;
			out_max = POS_LIM; int_max = POS_LIM; law = pcs_pkg::LAW_STANDARD;
			prev_err = 0; integ = 0; first = 1; used = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [pcs_pkg::CFG_IDX_W-1:0] idx,
				logic [pcs_pkg::CFG_W-1:0] val);
			case (idx)
				pcs_pkg::CFG_GAIN_P:  kp = longint'(signed'(val));
				pcs_pkg::CFG_GAIN_I:  ki = longint'(signed'(val));
				pcs_pkg::CFG_GAIN_D:  kd = longint'(signed'(val));
				pcs_pkg::CFG_MIN_OUT: out_min = longint'(val[30:0]);
				pcs_pkg::CFG_MAX_OUT: out_max = longint'(val[30:0]);
				pcs_pkg::CFG_MAX_INT: int_max = longint'(val[30:0]);
				pcs_pkg::CFG_LAW:     law = val[0];
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > POS_LIM) return POS_LIM;
			if (v < NEG_LIM) return NEG_LIM;
			return v;
		endfunction

		function longint signed_mag(longint unsigned m, bit neg);
			if (m > longint'(POS_LIM)) m = POS_LIM + neg;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		// product truncated toward zero to FB fraction bits, saturated
		function longint mul_q(longint a, longint b);
			longint unsigned ua, ub;
			ua = (a < 0) ? longint'(-a) : a;
			ub = (b < 0) ? longint'(-b) : b;
			return signed_mag((ua * ub) >> FB, (a < 0) != (b < 0));
		endfunction

		// (n << FB) / d for positive d, truncated toward zero, saturated
		function longint div_q(longint n, longint d);
			longint unsigned un;
			longint unsigned q;
			un = (n < 0) ? longint'(-n) : n;
			q = (un << FB) / longint'(d);
			if (q > longint'(POS_LIM)) q = POS_LIM + 1;
			return signed_mag(q, n < 0);
		endfunction

		// note an accepted word and queue the drive value it causes
		function void take_sample(logic cmd, logic [DW-1:0] raw);
			longint e, o, diff;
			if (cmd == pcs_pkg::CMD_CHECK) begin
				if (!used) first = 1;
				used = 0;
				return;
			end
			e = longint'(signed'(raw));
			used = 1;
			diff = sat(e - prev_err);
			if (law == pcs_pkg::LAW_STANDARD) begin
				integ += e;
				if (integ > int_max) integ = int_max;
				if (integ < -int_max) integ = -int_max;
				if (first) begin
					integ = 0;
					o = mul_q(kp, e);
					first = 0;
				end else begin
					o = sat(mul_q(kp, e) + mul_q(kd, diff) + mul_q(ki, integ));
				end
			end else begin
				// small sample answers zero and leaves the rest untouched
				if (e < SMALL_THR) begin
					drive_q.push_back('0);
					return;
				end
				if (first) begin
					integ = 0;
					o = mul_q(kp, e);
					first = 0;
				end else begin
					o = sat(mul_q(kp, e) + div_q(mul_q(kd, diff), e));
				end
				if (o > out_max) o = out_max;
				else if (o < -out_max) o = -out_max;
				// the minimum push wins over the maximum
				if (o < out_min && o > 0) o = out_min;
				else if (o > -out_min && o < 0) o = -out_min;
				o = sat(o);
			end
			prev_err = e;
			drive_q.push_back(o[DW-1:0]);
		endfunction

		function void check_drive(logic [DW-1:0] got);
			logic [DW-1:0] want;
			if (drive_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected drive word %h", got);
				return;
			end
			want = drive_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("control_out mismatch: expected %h, got %h", want, got);
			end
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [31:0]    s_tdata;
	logic           s_tuser;
	logic           m_tvalid;
	logic           m_tready;
	logic [31:0]    m_tdata;
	logic           cfg_we;
	logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcs_pkg::CFG_W-1:0]     cfg_data;

	pid_law_scoreboard sb;
	bit  s_fire, m_fire;
	bit  calm_tx, calm_rx;

	pid_controller_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// sample both streams at the rising edge
	always @(posedge clk) begin
		s_fire = s_tvalid && s_tready;
		m_fire = m_tvalid && m_tready;
		if (s_fire) sb.take_sample(s_tuser, s_tdata);
		if (m_fire) sb.check_drive(m_tdata);
	end

	// receiver: random stall before each word, none in calm stretches
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = calm_rx ? 0 : $urandom_range(0, 18);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_fire);
		end
	end

	// send one word; valid stays high across back-to-back words
	task automatic send_word(logic cmd, logic [31:0] err);
		int gap;
		gap = calm_tx ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= err;
		do @(negedge clk); while (!s_fire);
	endtask

	// drain all pending drive values, then let the sequencer settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// write every register while idle
	task automatic configure(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
			logic [31:0] mn, logic [31:0] mx, logic [31:0] mi, logic lw);
		logic [31:0] vals[7];
		vals = '{gp, gi, gd, mn, mx, mi, {$urandom} & 32'hFFFF_FFFE | lw};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= pcs_pkg::CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			sb.set_reg(pcs_pkg::CFG_IDX_W'(i), vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
		endcase
	endfunction

	function automatic logic [31:0] rand_limit();
		case ($urandom_range(0, 7))
			0: return 32'h0 | ($urandom & 32'h8000_0000);
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h80000) | ($urandom & 32'h8000_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_error();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(56, 76));
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh30000);
		endcase
	endfunction

	// stimulus
	initial begin
		logic [31:0] dir_err[8];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = pcs_pkg::CMD_COMPENSATE;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		calm_tx = 0; calm_rx = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// standard law: first step, extremes, check that keeps and restarts
		configure(32'h0001_0000, 32'h0000_8000, 32'hFFFE_0000,
			32'h0, 32'h7FFF_FFFF, 32'h0005_0000, pcs_pkg::LAW_STANDARD);
		dir_err = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h1, 32'h0003_0000, 32'h0003_0000, 32'hFFFC_0000};
		foreach (dir_err[i]) send_word(pcs_pkg::CMD_COMPENSATE, dir_err[i]);
		send_word(pcs_pkg::CMD_CHECK, $urandom);
		send_word(pcs_pkg::CMD_COMPENSATE, 32'h0002_0000);
		send_word(pcs_pkg::CMD_CHECK, $urandom);
		send_word(pcs_pkg::CMD_CHECK, $urandom);
		send_word(pcs_pkg::CMD_COMPENSATE, 32'h0002_0000);
		drain();

		// scaled law: threshold edges, negatives, min push over max limit
		configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h0004_0000, 32'h0002_0000, 32'h7FFF_FFFF, pcs_pkg::LAW_SCALED);
		dir_err = '{32'd65, 32'd66, 32'h0001_0000, 32'hFFFF_FFFB,
			32'h8000_0000, 32'h7FFF_FFFF, 32'd67, 32'h0000_8000};
		foreach (dir_err[i]) send_word(pcs_pkg::CMD_COMPENSATE, dir_err[i]);
		drain();

		// random phases under varied settings
		for (int ph = 0; ph < 12; ph++) begin
			configure(rand_gain(), rand_gain(), rand_gain(),
				rand_limit(), rand_limit(), rand_limit(), $urandom_range(0, 1));
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 140; k++) begin
				if ($urandom_range(0, 7) == 0) send_word(pcs_pkg::CMD_CHECK, $urandom);
				else send_word(pcs_pkg::CMD_COMPENSATE, rand_error());
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#60_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
